// ===== src/scan_polar_to_cartesian_top_assert.svh =====
// Assertion macros for the polar to Cartesian scan converter.
// Included by the top level; depends on nothing else.
`ifndef SCAN_POLAR_TO_CARTESIAN_TOP_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/spc_pkg.sv =====
// Shared types, widths and constants of the polar to Cartesian scan converter.
// Used by every module of the block; depends on nothing.
package spc_pkg;

	localparam int MAX_BEAMS_DEF     = 4096;
	localparam int CORDIC_STAGES_DEF = 18;

	localparam int RANGE_W = 20;
	localparam int IDX_W   = 12;
	localparam int ANGLE_W = 16;
	localparam int MAG_W   = 28;
	localparam int XY_W    = 31;
	localparam int Z_W     = 32;
	localparam int OUT_W   = 21;
	localparam int GUARD_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;

	// CORDIC gain compensation, Q30.
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	localparam int ATAN_N = 24;
	// atan(2^-i) in units of 2^32 per full turn.
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [IDX_W-1:0]       idx;
	} vec_t;

endpackage

// ===== src/spc_angle.sv =====
// Front end: beam index reduction, beam angle, gain-compensated range and
// quarter-turn reduction into the CORDIC start vector. Depends on spc_pkg.
module spc_angle #(
	parameter int MAX_BEAMS = spc_pkg::MAX_BEAMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [spc_pkg::RANGE_W-1:0]        range_value,
	input  logic [spc_pkg::IDX_W-1:0]          beam_index,
	input  logic [spc_pkg::ANGLE_W-1:0]        start_angle,
	input  logic signed [spc_pkg::ANGLE_W-1:0] angle_step,
	output logic                               out_valid,
	input  logic                               out_ready,
	output spc_pkg::vec_t                      out_vec
);

	localparam int RECIP_SH = 24;
	localparam logic [24:0] RECIP = 25'((2 ** RECIP_SH + MAX_BEAMS - 1) / MAX_BEAMS);
	localparam logic [16:0] BEAMS = 17'(MAX_BEAMS);
	localparam int PROD_W = 50;

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic                         rdy1, rdy2, rdy3, rdy4;
	logic [spc_pkg::IDX_W-1:0]    bidx_s1, q_s1, idx_s2, idx_s3;
	logic [spc_pkg::MAG_W-1:0]    mag_s1, mag_s2, mag_s3;
	logic [spc_pkg::ANGLE_W-1:0]  angle_s3;
	spc_pkg::vec_t                vec_s4;

	logic [36:0]                  recip_prod;
	logic [PROD_W-1:0]            gain_prod;
	logic [28:0]                  qm_prod;
	logic [27:0]                  step_prod;
	logic [spc_pkg::ANGLE_W-1:0]  quad_sum;
	logic [1:0]                   quad;
	logic [spc_pkg::ANGLE_W-1:0]  resid;
	logic signed [spc_pkg::XY_W-1:0] mag_pos, mag_neg;
	spc_pkg::vec_t                vec_d;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign recip_prod = 37'(beam_index) * 37'(RECIP);
	assign gain_prod  = PROD_W'(range_value) * PROD_W'(spc_pkg::GAIN_Q30)
		+ PROD_W'(1 << (29 - spc_pkg::GUARD_W));
	assign qm_prod    = 29'(q_s1) * 29'(BEAMS);
	assign step_prod  = 28'(idx_s2) * 28'($unsigned(angle_step));

	assign quad_sum = angle_s3 + 16'h2000;
	assign quad     = quad_sum[15:14];
	assign resid    = angle_s3 - {quad, 14'b0};
	assign mag_pos  = $signed(spc_pkg::XY_W'(mag_s3));
	assign mag_neg  = -mag_pos;

	always_comb begin
		vec_d.z   = $signed({resid, 16'b0});
		vec_d.idx = idx_s3;
		case (quad)
			2'd0: begin
				vec_d.x = mag_pos;
				vec_d.y = '0;
			end
			2'd1: begin
				vec_d.x = '0;
				vec_d.y = mag_pos;
			end
			2'd2: begin
				vec_d.x = mag_neg;
				vec_d.y = '0;
			end
			default: begin
				vec_d.x = '0;
				vec_d.y = mag_neg;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			bidx_s1 <= beam_index;
			q_s1    <= recip_prod[RECIP_SH +: spc_pkg::IDX_W];
			mag_s1  <= gain_prod[(30 - spc_pkg::GUARD_W) +: spc_pkg::MAG_W];
		end
		if (rdy2 && v_s1) begin
			idx_s2 <= bidx_s1 - qm_prod[spc_pkg::IDX_W-1:0];
			mag_s2 <= mag_s1;
		end
		if (rdy3 && v_s2) begin
			angle_s3 <= start_angle + step_prod[spc_pkg::ANGLE_W-1:0];
			idx_s3   <= idx_s2;
			mag_s3   <= mag_s2;
		end
		if (rdy4 && v_s3) begin
			vec_s4 <= vec_d;
		end
	end

	assign out_valid = v_s4;
	assign out_vec   = vec_s4;

endmodule

// ===== src/spc_cordic.sv =====
// Rotation-mode CORDIC, one registered micro-rotation per stage.
// Depends on spc_pkg for the vector type and the arctangent table.
module spc_cordic #(
	parameter int STAGES = spc_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  spc_pkg::vec_t in_vec,
	output logic          out_valid,
	input  logic          out_ready,
	output spc_pkg::vec_t out_vec
);

	spc_pkg::vec_t vec_sk   [STAGES+1];
	logic          valid_sk [STAGES+1];
	logic          rdy_sk   [STAGES+1];

	assign vec_sk[0]      = in_vec;
	assign valid_sk[0]    = in_valid;
	assign rdy_sk[STAGES] = out_ready;
	assign in_ready       = rdy_sk[0];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic signed [spc_pkg::XY_W-1:0] dx, dy;
		logic signed [spc_pkg::Z_W-1:0]  ang;
		spc_pkg::vec_t                   nxt;

		assign dx  = $signed(vec_sk[g].y) >>> g;
		assign dy  = $signed(vec_sk[g].x) >>> g;
		assign ang = $signed(spc_pkg::ATAN_TAB[g]);

		always_comb begin
			nxt.idx = vec_sk[g].idx;
			if (!vec_sk[g].z[spc_pkg::Z_W-1]) begin
				nxt.x = vec_sk[g].x - dx;
				nxt.y = vec_sk[g].y + dy;
				nxt.z = vec_sk[g].z - ang;
			end else begin
				nxt.x = vec_sk[g].x + dx;
				nxt.y = vec_sk[g].y - dy;
				nxt.z = vec_sk[g].z + ang;
			end
		end

		assign rdy_sk[g] = !valid_sk[g+1] || rdy_sk[g+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[g+1] <= 1'b0;
			end else if (rdy_sk[g]) begin
				valid_sk[g+1] <= valid_sk[g];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_sk[g] && valid_sk[g]) begin
				vec_sk[g+1] <= nxt;
			end
		end
	end

	assign out_valid = valid_sk[STAGES];
	assign out_vec   = vec_sk[STAGES];

endmodule

// ===== src/spc_round.sv =====
// Output stage: rounds the CORDIC result to whole units and saturates it.
// Depends on spc_pkg for widths and the vector type.
module spc_round (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  spc_pkg::vec_t                     in_vec,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [spc_pkg::OUT_W-1:0]  point_x,
	output logic signed [spc_pkg::OUT_W-1:0]  point_y,
	output logic [spc_pkg::IDX_W-1:0]         point_index
);

	localparam int SUM_W = spc_pkg::XY_W + 1;
	localparam int RND_W = SUM_W - spc_pkg::GUARD_W;
	localparam logic signed [RND_W-1:0] LIM_HI = RND_W'(1048575);
	localparam logic signed [RND_W-1:0] LIM_LO = -LIM_HI;

	function automatic logic signed [spc_pkg::OUT_W-1:0] finish_f(
		input logic signed [spc_pkg::XY_W-1:0] v
	);
		logic signed [SUM_W-1:0] sum;
		logic signed [RND_W-1:0] r;
		sum = SUM_W'(v) + SUM_W'(1 << (spc_pkg::GUARD_W - 1));
		r   = RND_W'(sum >>> spc_pkg::GUARD_W);
		if (r > LIM_HI) begin
			r = LIM_HI;
		end else if (r < LIM_LO) begin
			r = LIM_LO;
		end
		return r[spc_pkg::OUT_W-1:0];
	endfunction

	logic                             v_s1;
	logic signed [spc_pkg::OUT_W-1:0] x_s1, y_s1;
	logic [spc_pkg::IDX_W-1:0]        idx_s1;

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1   <= finish_f(in_vec.x);
			y_s1   <= finish_f(in_vec.y);
			idx_s1 <= in_vec.idx;
		end
	end

	assign out_valid   = v_s1;
	assign point_x     = x_s1;
	assign point_y     = y_s1;
	assign point_index = idx_s1;

endmodule

// ===== src/scan_polar_to_cartesian_top.sv =====
// Throughput: one item per cycle unless stalled; the CORDIC_STAGES micro-rotation
// stages, four front-end stages and one rounding stage each hold one item.
// A stall holds every full stage whose successor cannot accept; bubbles are filled.
// Reset clears all valid bits and sets both angle registers to zero.
// Depends on spc_pkg, spc_angle, spc_cordic, spc_round and the assertion header.
module scan_polar_to_cartesian_top #(
	parameter int MAX_BEAMS     = spc_pkg::MAX_BEAMS_DEF,
	parameter int CORDIC_STAGES = spc_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spc_pkg::ANGLE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [spc_pkg::RANGE_W-1:0]         range_value,
	input  logic [spc_pkg::IDX_W-1:0]           beam_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [spc_pkg::OUT_W-1:0]    point_x,
	output logic signed [spc_pkg::OUT_W-1:0]    point_y,
	output logic [spc_pkg::IDX_W-1:0]           point_index
);

	`include "scan_polar_to_cartesian_top_assert.svh"

	logic [spc_pkg::ANGLE_W-1:0]        start_angle_q;
	logic signed [spc_pkg::ANGLE_W-1:0] angle_step_q;

	logic          a_valid, a_ready, c_valid, c_ready;
	spc_pkg::vec_t a_vec, c_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spc_pkg::REG_START_ANGLE: start_angle_q <= cfg_data;
				spc_pkg::REG_ANGLE_STEP:  angle_step_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	spc_angle #(
		.MAX_BEAMS(MAX_BEAMS)
	) u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.range_value(range_value),
		.beam_index (beam_index),
		.start_angle(start_angle_q),
		.angle_step (angle_step_q),
		.out_valid  (a_valid),
		.out_ready  (a_ready),
		.out_vec    (a_vec)
	);

	spc_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (a_valid),
		.in_ready (a_ready),
		.in_vec   (a_vec),
		.out_valid(c_valid),
		.out_ready(c_ready),
		.out_vec  (c_vec)
	);

	spc_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (c_valid),
		.in_ready   (c_ready),
		.in_vec     (c_vec),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_index(point_index)
	);

	// An empty output stage means nothing upstream can be held back.
	`SPC_ASSERT_NOW(a_ready_when_drained, clk, arst_n, !out_valid, in_ready, "input stalled with empty output")

	`SPC_ASSERT_NOW(a_saturated, clk, arst_n, out_valid, (point_x >= -21'sd1048575) && (point_y >= -21'sd1048575), "point outside saturation limits")

	`SPC_ASSERT_NEXT(a_cfg_unknown, clk, arst_n, cfg_we && (cfg_index != spc_pkg::REG_START_ANGLE) && (cfg_index != spc_pkg::REG_ANGLE_STEP), $stable(start_angle_q) && $stable(angle_step_q), "write to unknown register changed state")

endmodule

// ===== test/scan_polar_to_cartesian_top_test.sv =====
// Self-checking testbench for the polar to Cartesian scan converter top level.
// Computes every expected point with its own CORDIC predictor and checks each item.
// Depends on spc_pkg and scan_polar_to_cartesian_top.
`timescale 1ns / 100ps

module scan_polar_to_cartesian_top_test;

	localparam int RANGE_W   = spc_pkg::RANGE_W;
	localparam int IDX_W     = spc_pkg::IDX_W;
	localparam int ANGLE_W   = spc_pkg::ANGLE_W;
	localparam int OUT_W     = spc_pkg::OUT_W;
	localparam int GUARD_W   = spc_pkg::GUARD_W;
	localparam int CFG_IDX_W = spc_pkg::CFG_IDX_W;

	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = spc_pkg::REG_START_ANGLE;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = spc_pkg::REG_ANGLE_STEP;

	localparam int BEAMS      = 4096;
	localparam int STAGES     = 18;
	localparam int LATENCY    = STAGES + 5;
	localparam int IDLE_LIMIT = 4000;
	localparam int PRINT_CAP  = 40;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam longint GAIN      = 64'd652032874;
	localparam longint SAT_LIMIT = 64'd1048575;
	localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

	localparam longint ARCTAN [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
	};

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [IDX_W-1:0]        idx;
	} point_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [ANGLE_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [RANGE_W-1:0]        range_value;
	logic [IDX_W-1:0]          beam_index;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [OUT_W-1:0]   point_x;
	logic signed [OUT_W-1:0]   point_y;
	logic [IDX_W-1:0]          point_index;

	logic [ANGLE_W-1:0] model_start_angle;
	logic [ANGLE_W-1:0] model_angle_step;
	point_t             pending_points [$];
	point_t             oldest_point;
	int                 mismatches;
	int                 items_sent;
	int                 points_checked;
	int                 register_writes;
	int                 idle_cycles;
	int                 in_gap_max;
	int                 out_gap_max;

	scan_polar_to_cartesian_top #(
		.MAX_BEAMS    (BEAMS),
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.range_value(range_value),
		.beam_index (beam_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_index(point_index)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic signed [OUT_W-1:0] round_saturate(input longint v);
		longint r;
		r = (v + 64'sd128) >>> GUARD_W;
		if (r > SAT_LIMIT)
			r = SAT_LIMIT;
		if (r < -SAT_LIMIT)
			r = -SAT_LIMIT;
		return r[OUT_W-1:0];
	endfunction

	function automatic point_t rotate_beam(input logic [RANGE_W-1:0] rng,
		input logic [IDX_W-1:0] bidx);
		point_t             p;
		logic [IDX_W-1:0]   idx;
		logic [31:0]        prod;
		logic [ANGLE_W-1:0] angle;
		logic [16:0]        centered;
		logic [1:0]         quad;
		logic [ANGLE_W-1:0] resid_bits;
		longint             resid;
		longint             mag;
		longint             x;
		longint             y;
		longint             z;
		longint             dx;
		longint             dy;
		idx = IDX_W'(bidx % BEAMS);
		prod = 32'(idx) * 32'(model_angle_step);
		angle = model_start_angle + prod[ANGLE_W-1:0];
		centered = {1'b0, angle} + 17'h2000;
		quad = centered[15:14];
		resid_bits = angle - {quad, 14'b0};
		resid = $signed(resid_bits);
		mag = (longint'(rng) * GAIN + (64'sd1 << 21)) >>> 22;
		case (quad)
			2'd0: begin
				x = mag;
				y = 0;
			end
			2'd1: begin
				x = 0;
				y = mag;
			end
			2'd2: begin
				x = -mag;
				y = 0;
			end
			default: begin
				x = 0;
				y = -mag;
			end
		endcase
		z = resid * 65536;
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN[i];
			end
		end
		p.x = round_saturate(x);
		p.y = round_saturate(y);
		p.idx = idx;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected point, index", point_index, -1);
			end else begin
				oldest_point = pending_points.pop_front();
				points_checked++;
				if (point_x !== oldest_point.x)
					report_mismatch("point_x", point_x, oldest_point.x);
				if (point_y !== oldest_point.y)
					report_mismatch("point_y", point_y, oldest_point.y);
				if (point_index !== oldest_point.idx)
					report_mismatch("point_index", point_index, oldest_point.idx);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d points outstanding", pending_points.size());
			$display("scan_polar_to_cartesian_top: mismatch");
			$finish;
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, out_gap_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Entered and left at a falling edge; the item stays valid until accepted.
	task automatic send_item(input logic [RANGE_W-1:0] rng, input logic [IDX_W-1:0] bidx);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		range_value <= rng;
		beam_index <= bidx;
		do @(posedge clk); while (!in_ready);
		pending_points.push_back(rotate_beam(rng, bidx));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		register_writes++;
		if (idx == REG_START_ANGLE)
			model_start_angle = data;
		else if (idx == REG_ANGLE_STEP)
			model_angle_step = data;
	endtask

	task automatic set_angles(input logic [ANGLE_W-1:0] start, input logic [ANGLE_W-1:0] step);
		drain_pipeline();
		write_register(REG_START_ANGLE, start);
		write_register(REG_ANGLE_STEP, step);
	endtask

	function automatic logic [RANGE_W-1:0] pick_range();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return RANGE_MAX;
			2: return RANGE_W'($urandom_range(0, 15));
			default: return RANGE_W'($urandom());
		endcase
	endfunction

	task automatic test_reset_state();
		send_item('0, '0);
		send_item(RANGE_MAX, '0);
		send_item(20'h12345, 12'hFFF);
		send_item(RANGE_MAX, 12'hFFF);
	endtask

	task automatic test_quadrant_boundaries();
		set_angles(16'h0000, 16'h2000);
		for (int i = 0; i < 8; i++)
			send_item(RANGE_MAX, IDX_W'(i));
		set_angles(16'h2000, 16'hFFFF);
		send_item(RANGE_MAX, 12'd0);
		send_item(RANGE_MAX, 12'd1);
		send_item(20'h80000, 12'hFFF);
	endtask

	task automatic test_angle_extremes();
		set_angles(16'hFFFF, 16'h8000);
		send_item(20'd1, 12'd0);
		send_item(RANGE_MAX, 12'd1);
		send_item(20'h80000, 12'd2);
		send_item('0, 12'hFFF);
		set_angles(16'h0000, 16'h7FFF);
		send_item(RANGE_MAX, 12'hFFF);
		send_item(RANGE_MAX, 12'd1);
	endtask

	task automatic test_unknown_registers();
		set_angles(16'h1000, 16'h0123);
		write_register(REG_SPARE_2, 16'hFFFF);
		write_register(REG_SPARE_3, 16'hA5A5);
		send_item(20'h0ABCD, 12'd5);
		send_item(RANGE_MAX, 12'h800);
	endtask

	task automatic test_random_scans(input int segments, input int per_segment);
		logic [ANGLE_W-1:0] start;
		logic [ANGLE_W-1:0] step;
		logic [IDX_W-1:0]   next_beam;
		int                 pace;
		for (int s = 0; s < segments; s++) begin
			case ($urandom_range(0, 5))
				0: start = '0;
				1: start = 16'hFFFF;
				default: start = ANGLE_W'($urandom());
			endcase
			case ($urandom_range(0, 7))
				0: step = 16'h8000;
				1: step = 16'h7FFF;
				2: step = 16'h0000;
				3: step = 16'hFFFF;
				4: step = 16'h0001;
				default: step = ANGLE_W'($urandom());
			endcase
			drain_pipeline();
			if ($urandom_range(0, 1)) begin
				write_register(REG_ANGLE_STEP, step);
				write_register(REG_START_ANGLE, start);
			end else begin
				write_register(REG_START_ANGLE, start);
				write_register(REG_ANGLE_STEP, step);
			end
			pace = $urandom_range(0, 3);
			in_gap_max = (pace == 0) ? 0 : (pace == 1) ? 3 : 13;
			pace = $urandom_range(0, 3);
			out_gap_max = (pace == 0) ? 0 : (pace == 1) ? 3 : 13;
			next_beam = ($urandom_range(0, 1)) ? '0 : IDX_W'($urandom());
			for (int n = 0; n < per_segment; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					send_item(pick_range(), next_beam);
					next_beam = next_beam + 1'b1;
				end else begin
					send_item(pick_range(), IDX_W'($urandom()));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		range_value = '0;
		beam_index = '0;
		model_start_angle = '0;
		model_angle_step = '0;
		mismatches = 0;
		items_sent = 0;
		points_checked = 0;
		register_writes = 0;
		idle_cycles = 0;
		in_gap_max = 13;
		out_gap_max = 13;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_quadrant_boundaries();
		test_angle_extremes();
		test_unknown_registers();
		test_random_scans(13, 100);

		drain_pipeline();
		repeat (LATENCY + 16) @(negedge clk);
		$display("Sent %0d items and checked %0d points across %0d register writes.",
			items_sent, points_checked, register_writes);
		$display("Covered all quadrants, angle extremes, spare register indexes and saturation.");
		if (mismatches == 0 && pending_points.size() == 0)
			$display("scan_polar_to_cartesian_top: match");
		else
			$display("scan_polar_to_cartesian_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/spc_pkg.sv
src/spc_angle.sv
src/spc_cordic.sv
src/spc_round.sv
src/scan_polar_to_cartesian_top.sv
test/scan_polar_to_cartesian_top_test.sv
